// ----- sv/oah_pkg.sv -----
// ============================================================================
// oah_pkg
// Shared types and constants for the open addressing hash table.
// ============================================================================
package oah_pkg;

    // Request codes on req_type.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOPLACE  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_WALK,
        S_FINISH,
        S_WRITE2
    } state_t;

    // Golden-ratio fraction in unsigned 0.32 fixed point.
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B9;

endpackage

// ----- sv/open_addressing_hash_table.sv -----
// ============================================================================
// open_addressing_hash_table
// Fixed-size table of nonzero 32-bit keys with multiplicative hashing and
// quadratic probing; serves insert, delete, update and lookup requests.
// ============================================================================
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------
//  request   req_valid/req_stall  req_type, key, new_key
//  response  rsp_valid/rsp_stall  status, slot_index, entry_count
//
// A request is accepted, passes S_HASH1 and S_HASH2 in the shared multiplier
// for the home slot, and walks the probe sequence, issuing one slot read per
// cycle from the store, whose read data is registered; the result is then
// written back. An update walks twice and then clears the old slot.
// Requests with a zero key (or a zero new_key on an update), and deletes or
// updates on an empty table, skip the hash and the probe walk.
// After reset the store is cleared one slot per cycle with req_stall high.
// A stalled response holds the write-back until taken.

module open_addressing_hash_table #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        req_type,
    input  logic signed [31:0]                key,
    input  logic signed [31:0]                new_key,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [2:0]                        status,
    output logic [$clog2(CAPACITY)-1:0]       slot_index,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count
);

    import oah_pkg::*;

    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int STEP0 = 3 % CAPACITY;
    localparam int INC   = 4 % CAPACITY;

    // Slot store.
    logic [31:0] mem [CAPACITY];
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    // Sequencer and request registers.
    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   nkey_reg, nkey_next;
    logic [31:0]   target_reg, target_next;
    logic          place_reg, place_next;
    logic          phase2_reg, phase2_next;
    logic [31:0]   prod_reg, prod_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] step_reg, step_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic          iss_done_reg, iss_done_next;
    logic [IW-1:0] old_reg, old_next;
    logic [IW-1:0] slot_reg, slot_next;
    status_t       res_status_reg, res_status_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] clr_reg, clr_next;

    // Read pipeline.
    logic [31:0]   rd_data_reg;
    logic [IW-1:0] rd_pos_reg, rd_pos_next;
    logic          rd_last_reg, rd_last_next;
    logic          rd_vld_reg, rd_vld_next;

    // Response registers.
    logic          rsp_valid_reg, rsp_valid_next;
    status_t       rsp_status_reg, rsp_status_next;
    logic [IW-1:0] rsp_slot_reg, rsp_slot_next;
    logic [CW-1:0] rsp_count_reg, rsp_count_next;

    // Shared multiplier, probe adders and helpers.
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [IW:0]   pos_sum, pos_wrap;
    logic [IW:0]   step_sum, step_wrap;
    logic          fin_fire;
    logic          rd_empty, rd_match;

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign slot_index  = rsp_slot_reg;
    assign entry_count = rsp_count_reg;

    // One multiplier: key times the hash constant, then the product scaled
    // by the capacity to pick the home slot.
    assign mul_a = (state_reg == S_HASH1) ? target_reg : prod_reg;
    assign mul_b = (state_reg == S_HASH1) ? HASH_MULT : 32'(CAPACITY);
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // Next probe position: consecutive probes differ by 4i-1, so both the
    // position and the step advance by one modular add.
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_wrap  = (pos_sum >= (IW+1)'(CAPACITY)) ? pos_sum - (IW+1)'(CAPACITY) : pos_sum;
    assign step_sum  = {1'b0, step_reg} + (IW+1)'(INC);
    assign step_wrap = (step_sum >= (IW+1)'(CAPACITY)) ? step_sum - (IW+1)'(CAPACITY)
                                                       : step_sum;

    assign rd_empty = (rd_data_reg == 32'd0);
    assign rd_match = (rd_data_reg == target_reg);
    assign fin_fire = (state_reg == S_FINISH) && !(rsp_valid_reg && rsp_stall);

    // Next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        nkey_next       = nkey_reg;
        target_next     = target_reg;
        place_next      = place_reg;
        phase2_next     = phase2_reg;
        prod_next       = prod_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        iss_cnt_next    = iss_cnt_reg;
        iss_done_next   = iss_done_reg;
        old_next        = old_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        rd_pos_next     = pos_reg;
        rd_last_next    = (iss_cnt_reg == CW'(CAPACITY));
        rd_vld_next     = 1'b0;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_count_next  = rsp_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = 32'd0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req_t'(req_type);
                    key_next    = $unsigned(key);
                    nkey_next   = $unsigned(new_key);
                    target_next = $unsigned(key);
                    place_next  = (req_t'(req_type) == REQ_INSERT);
                    phase2_next = 1'b0;
                    slot_next   = '0;
                    if ((key == 32'sd0) ||
                        ((req_t'(req_type) == REQ_UPDATE) && (new_key == 32'sd0)))
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_FINISH;
                    end
                    else if (((req_t'(req_type) == REQ_DELETE) ||
                              (req_t'(req_type) == REQ_UPDATE)) && (count_reg == '0))
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_HASH1;
                    end
                end
            end

            S_HASH1:
            begin
                prod_next  = mul_p[31:0];
                state_next = S_HASH2;
            end

            S_HASH2:
            begin
                pos_next      = mul_p[32 +: IW];
                step_next     = IW'(STEP0);
                iss_cnt_next  = '0;
                iss_done_next = 1'b0;
                state_next    = S_WALK;
            end

            S_WALK:
            begin
                // Issue one slot read per cycle until the last probe.
                if (!iss_done_reg)
                begin
                    pos_next      = pos_wrap[IW-1:0];
                    step_next     = step_wrap[IW-1:0];
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                    iss_done_next = (iss_cnt_reg == CW'(CAPACITY));
                    rd_vld_next   = 1'b1;
                end

                // Examine the slot read in the previous cycle.
                if (rd_vld_reg)
                begin
                    if ((place_reg && rd_empty) || (!place_reg && rd_match))
                    begin
                        rd_vld_next = 1'b0;
                        if ((req_reg == REQ_UPDATE) && !phase2_reg)
                        begin
                            // Old key found: now place the new key.
                            old_next    = rd_pos_reg;
                            target_next = nkey_reg;
                            place_next  = 1'b1;
                            phase2_next = 1'b1;
                            state_next  = S_HASH1;
                        end
                        else
                        begin
                            slot_next       = rd_pos_reg;
                            res_status_next = ST_DONE;
                            state_next      = S_FINISH;
                        end
                    end
                    else if ((place_reg && rd_match) || rd_last_reg)
                    begin
                        rd_vld_next     = 1'b0;
                        slot_next       = '0;
                        res_status_next = place_reg ? ST_NOPLACE : ST_NOTFOUND;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (fin_fire)
                begin
                    mem_waddr = slot_reg;
                    if (res_status_reg == ST_DONE)
                    begin
                        case (req_reg)
                            REQ_INSERT:
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = key_reg;
                                count_next = count_reg + 1'b1;
                            end
                            REQ_DELETE:
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            REQ_UPDATE:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = nkey_reg;
                            end
                            default:
                            begin
                                mem_we = 1'b0;
                            end
                        endcase
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = slot_reg;
                    rsp_count_next  = count_next;
                    if ((req_reg == REQ_UPDATE) && (res_status_reg == ST_DONE))
                    begin
                        state_next = S_WRITE2;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_WRITE2:
            begin
                // Clear the slot that held the old key.
                mem_we     = 1'b1;
                mem_waddr  = old_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            iss_done_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            iss_done_reg  <= iss_done_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        nkey_reg       <= nkey_next;
        target_reg     <= target_next;
        place_reg      <= place_next;
        phase2_reg     <= phase2_next;
        prod_reg       <= prod_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        iss_cnt_reg    <= iss_cnt_next;
        old_reg        <= old_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        rd_pos_reg     <= rd_pos_next;
        rd_last_reg    <= rd_last_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_count_reg  <= rsp_count_next;
    end

    // Slot store with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[pos_reg];
    end

    // Checks.
    a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != ST_DONE)) |-> (slot_index == '0))
        else $error("slot_index nonzero on a failed request");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && (req_reg == REQ_INSERT) && (res_status_reg == ST_DONE))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("successful insert did not raise the entry count");

    a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_WALK))
        else $error("slot read pending outside the probe walk");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

endmodule
